// ===== design/lu_decompose_partial_pivot_defines.svh =====
// ----------------------------------------------------------------------------
// LU decomposition assertion macros
// Concurrent assertion helpers used by the LU decomposition controller.
// ----------------------------------------------------------------------------
`ifndef LU_DECOMPOSE_PARTIAL_PIVOT_DEFINES_SVH
`define LU_DECOMPOSE_PARTIAL_PIVOT_DEFINES_SVH

`ifndef SYNTH
`define LUP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LUP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LUP_ASSERT_IMP(name, ante, cons, msg)
`define LUP_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// ===== design/lup_pkg.sv =====
// ----------------------------------------------------------------------------
// LU decomposition package
// Sizes, codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package lup_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W   = 32;
  localparam int TOL_W    = DATA_W - 1;
  localparam int OP_W     = 2;
  localparam int SEL_W    = 2;
  localparam int IN_IDX_W = 3;
  localparam int DIMF_W   = 4;
  localparam int SWAP_W   = 3;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [DATA_W-1:0] ONE_Q  = DATA_W'(longint'(1) << FRAC_BITS);
  localparam logic [DATA_W-1:0] DMAX_Q = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DMIN_Q = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_DECOMP = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [SEL_W-1:0] {
    MSEL_P = 2'd0,
    MSEL_L = 2'd1,
    MSEL_U = 2'd2
  } msel_t;

  typedef enum logic [2:0] {
    WS_HOST,
    WS_RD,
    WS_TMP,
    WS_ELIM,
    WS_UPD
  } wsel_t;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_P,
    SRC_L,
    SRC_U,
    SRC_DONE
  } osrc_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] rd_col;
    logic [IDX_W-1:0] wr_row;
    logic [IDX_W-1:0] wr_col;
    logic [IDX_W-1:0] perm_addr;
    logic [IDX_W-1:0] perm_wrow;
    logic             we_u;
    logic             we_l;
    wsel_t            wsel;
    logic             host_cap;
    logic             l_clear;
    logic             cap_a;
    logic             best_init;
    logic             best_upd;
    logic             pv_load;
    logic             div_start;
    logic             f_load;
    logic             uxi_load;
    logic             mul_load;
    logic             perm_init;
    logic             perm_cap;
    logic             perm_we;
    logic             perm_wtmp;
    logic             swaps_clr;
    logic             swaps_inc;
    logic             out_load;
    osrc_t            out_src;
  } cmd_t;

  typedef struct packed {
    logic better;
    logic best_zero;
    logic cur_zero;
    logic div_busy;
  } stat_t;

endpackage

// ===== design/lup_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lup_datapath.sv =====
// ----------------------------------------------------------------------------
// LU decomposition datapath
// Holds the L and U stores, permutation, divider, multiply-subtract unit,
// tolerance register and result registers.
// ----------------------------------------------------------------------------
module lup_datapath
  import lup_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [DATA_W-1:0]  in_element_value,
  input  logic               cfg_we,
  input  logic [TOL_W-1:0]   cfg_data,
  output logic               out_result_kind,
  output logic [DATA_W-1:0]  out_read_value,
  output logic [SWAP_W-1:0]  out_swap_count
);

  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int PROD_W = 2 * DATA_W;
  localparam int Q_W    = PROD_W - FRAC_BITS;
  localparam int DIFF_W = Q_W + 1;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [AW-1:0] lup_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
    return AW'(int'(row) * MAX_DIM + int'(col));
  endfunction

  logic [TOL_W-1:0]  tol_r;
  logic [DATA_W-1:0] host_r;
  logic [DATA_W-1:0] tol_ext;

  logic [AW-1:0]     waddr, raddr, raddr_q_r;
  logic [IDX_W-1:0]  rrow_q_r, rcol_q_r;
  logic [DATA_W-1:0] u_rd, l_rd, l_eff, u_wdata, l_wdata;
  logic [DEPTH-1:0]  lvalid_r;
  logic [DATA_W-1:0] a_u_r, a_l_r;

  logic [IDX_W-1:0]  perm_r [MAX_DIM];
  logic [IDX_W-1:0]  ptmp_r, perm_rd;
  logic [SWAP_W-1:0] swaps_r;

  logic [DATA_W-1:0] mag_rd, best_r;

  logic [DATA_W-1:0] dvs_r;
  logic              pv_sign_r, neg_r, busy_r;
  logic [DATA_W-1:0] rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W+1:0] trial;
  logic [DATA_W-1:0] fcomb;
  logic              ovf_pos, ovf_neg;

  logic signed [DATA_W-1:0] f_r, uxi_r, uyi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     adj;
  logic signed [Q_W-1:0]    qv;
  logic signed [DIFF_W-1:0] diff;
  logic                     sat_hi, sat_lo;
  logic [DATA_W-1:0]        vsat, vupd;

  assign tol_ext = {1'b0, tol_r};
  assign waddr   = lup_addr(cmd.wr_row, cmd.wr_col);
  assign raddr   = lup_addr(cmd.rd_row, cmd.rd_col);

  lup_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_upper (
    .clk   (clk),
    .we    (cmd.we_u),
    .waddr (waddr),
    .wdata (u_wdata),
    .raddr (raddr),
    .rdata (u_rd)
  );

  lup_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_lower (
    .clk   (clk),
    .we    (cmd.we_l),
    .waddr (waddr),
    .wdata (l_wdata),
    .raddr (raddr),
    .rdata (l_rd)
  );

  assign l_eff = lvalid_r[raddr_q_r] ? l_rd :
                 ((rrow_q_r == rcol_q_r) ? ONE_Q : '0);

  always_comb begin
    case (cmd.wsel)
      WS_HOST: u_wdata = host_r;
      WS_RD:   u_wdata = u_rd;
      WS_TMP:  u_wdata = a_u_r;
      WS_UPD:  u_wdata = vupd;
      default: u_wdata = '0;
    endcase
    case (cmd.wsel)
      WS_RD:   l_wdata = l_eff;
      WS_TMP:  l_wdata = a_l_r;
      WS_ELIM: l_wdata = f_r;
      default: l_wdata = '0;
    endcase
  end

  assign perm_rd = perm_r[cmd.perm_addr];

  assign mag_rd         = mag(u_rd);
  assign stat.better    = mag_rd > best_r;
  assign stat.best_zero = best_r <= tol_ext;
  assign stat.cur_zero  = mag_rd <= tol_ext;
  assign stat.div_busy  = busy_r;

  assign trial = {1'b0, rem_r, quo_r[DVD_W-1]} - {2'b00, dvs_r};

  assign ovf_pos = |quo_r[DVD_W-1:DATA_W-1];
  assign ovf_neg = (|quo_r[DVD_W-1:DATA_W]) || (quo_r[DATA_W-1] && (|quo_r[DATA_W-2:0]));
  always_comb begin
    if (!neg_r) begin
      fcomb = ovf_pos ? DMAX_Q : quo_r[DATA_W-1:0];
    end else begin
      fcomb = ovf_neg ? DMIN_Q : (~quo_r[DATA_W-1:0] + 1'b1);
    end
  end

  assign adj    = prod_r[PROD_W-1] && (|prod_r[FRAC_BITS-1:0]);
  assign qv     = Q_W'(prod_r >>> FRAC_BITS) + Q_W'(adj);
  assign diff   = DIFF_W'(uyi_r) - DIFF_W'(qv);
  assign sat_hi = !diff[DIFF_W-1] && (|diff[DIFF_W-2:DATA_W-1]);
  assign sat_lo = diff[DIFF_W-1] && !(&diff[DIFF_W-2:DATA_W-1]);
  assign vsat   = sat_hi ? DMAX_Q : (sat_lo ? DMIN_Q : diff[DATA_W-1:0]);
  assign vupd   = (mag(vsat) <= tol_ext) ? '0 : vsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_W'(1);
      lvalid_r <= '0;
      swaps_r  <= '0;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      for (int k = 0; k < MAX_DIM; k++) begin
        perm_r[k] <= IDX_W'(k);
      end
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_data;
      end
      if (cmd.l_clear) begin
        lvalid_r <= '0;
      end else if (cmd.we_l) begin
        lvalid_r[waddr] <= 1'b1;
      end
      if (cmd.swaps_clr) begin
        swaps_r <= '0;
      end else if (cmd.swaps_inc) begin
        swaps_r <= swaps_r + 1'b1;
      end
      if (cmd.perm_init) begin
        for (int k = 0; k < MAX_DIM; k++) begin
          perm_r[k] <= IDX_W'(k);
        end
      end else if (cmd.perm_we) begin
        perm_r[cmd.perm_wrow] <= cmd.perm_wtmp ? ptmp_r : perm_rd;
      end
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_q_r <= raddr;
    rrow_q_r  <= cmd.rd_row;
    rcol_q_r  <= cmd.rd_col;
    if (cmd.host_cap) begin
      host_r <= in_element_value;
    end
    if (cmd.cap_a) begin
      a_u_r <= u_rd;
      a_l_r <= l_eff;
    end
    if (cmd.perm_cap) begin
      ptmp_r <= perm_rd;
    end
    if (cmd.best_init) begin
      best_r <= mag_rd;
    end else if (cmd.best_upd) begin
      best_r <= mag_rd;
    end
    if (cmd.pv_load) begin
      dvs_r     <= mag_rd;
      pv_sign_r <= u_rd[DATA_W-1];
    end
    if (cmd.div_start) begin
      quo_r <= {mag_rd, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      neg_r <= u_rd[DATA_W-1] ^ pv_sign_r;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], !trial[DATA_W+1]};
      rem_r <= trial[DATA_W+1] ? {rem_r[DATA_W-2:0], quo_r[DVD_W-1]} : trial[DATA_W-1:0];
    end
    if (cmd.f_load) begin
      f_r <= fcomb;
    end
    if (cmd.uxi_load) begin
      uxi_r <= u_rd;
    end
    if (cmd.mul_load) begin
      prod_r <= f_r * uxi_r;
      uyi_r  <= u_rd;
    end
    if (cmd.out_load) begin
      out_result_kind <= (cmd.out_src == SRC_DONE) ? KIND_DONE : KIND_READ;
      out_swap_count  <= swaps_r;
      case (cmd.out_src)
        SRC_P:   out_read_value <= (perm_rd == cmd.rd_col) ? ONE_Q : '0;
        SRC_L:   out_read_value <= l_eff;
        SRC_U:   out_read_value <= u_rd;
        default: out_read_value <= '0;
      endcase
    end
  end

endmodule

// ===== design/lup_ctrl.sv =====
// ----------------------------------------------------------------------------
// LU decomposition controller
// Command decode, loop counters and sequencing of the factorisation.
// ----------------------------------------------------------------------------
`include "lu_decompose_partial_pivot_defines.svh"

module lup_ctrl
  import lup_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [IN_IDX_W-1:0] in_row_index,
  input  logic [IN_IDX_W-1:0] in_col_index,
  input  logic [SEL_W-1:0]    in_matrix_select,
  input  logic [DIMF_W-1:0]   in_dimension,
  output logic                out_valid,
  input  logic                out_ready,
  output cmd_t                cmd,
  input  stat_t               stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_RD, S_RDO, S_INIT,
    S_PS0, S_PS1, S_PSR, S_PSC, S_PZ,
    S_SW1, S_SW2, S_SW3, S_SW4,
    S_PV0, S_PV1, S_E1, S_E2, S_DIV, S_EW,
    S_I1, S_I2, S_I3, S_I4, S_YNEXT, S_NEXT, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [DIM_W-1:0]    x_r, x_nxt, y_r, y_nxt, i_r, i_nxt, piv_r, piv_nxt, n_r, n_nxt;
  logic [IN_IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic                inside_r, inside_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;
  logic [DIM_W-1:0]    dim_clamp;

  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    if (in_dimension == '0) begin
      dim_clamp = DIM_W'(1);
    end else if (int'(in_dimension) > MAX_DIM) begin
      dim_clamp = DIM_W'(MAX_DIM);
    end else begin
      dim_clamp = DIM_W'(in_dimension);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    i_nxt         = i_r;
    piv_nxt       = piv_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sel_nxt       = sel_r;
    inside_nxt    = inside_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = !out_valid_r || out_ready;
        cmd.host_cap = in_fire;
        if (in_fire) begin
          row_nxt    = in_row_index;
          col_nxt    = in_col_index;
          sel_nxt    = in_matrix_select;
          inside_nxt = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
          case (in_opcode)
            OP_WRITE:  state_nxt = S_WR;
            OP_READ:   state_nxt = S_RD;
            OP_DECOMP: begin
              n_nxt     = dim_clamp;
              x_nxt     = '0;
              state_nxt = S_INIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        cmd.we_u   = inside_r;
        cmd.wr_row = IDX_W'(row_r);
        cmd.wr_col = IDX_W'(col_r);
        cmd.wsel   = WS_HOST;
        state_nxt  = S_IDLE;
      end
      S_RD: begin
        cmd.rd_row = IDX_W'(row_r);
        cmd.rd_col = IDX_W'(col_r);
        state_nxt  = S_RDO;
      end
      S_RDO: begin
        cmd.rd_col    = IDX_W'(col_r);
        cmd.perm_addr = IDX_W'(row_r);
        cmd.out_load  = 1'b1;
        if (!inside_r) begin
          cmd.out_src = SRC_ZERO;
        end else begin
          case (sel_r)
            MSEL_P:  cmd.out_src = SRC_P;
            MSEL_L:  cmd.out_src = SRC_L;
            MSEL_U:  cmd.out_src = SRC_U;
            default: cmd.out_src = SRC_ZERO;
          endcase
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_INIT: begin
        cmd.l_clear   = 1'b1;
        cmd.perm_init = 1'b1;
        cmd.swaps_clr = 1'b1;
        x_nxt         = '0;
        state_nxt     = S_PS0;
      end
      S_PS0: begin
        cmd.rd_row = IDX_W'(x_r);
        cmd.rd_col = IDX_W'(x_r);
        piv_nxt    = x_r;
        y_nxt      = x_r + 1'b1;
        state_nxt  = S_PS1;
      end
      S_PS1: begin
        cmd.best_init = 1'b1;
        state_nxt     = (y_r < n_r) ? S_PSR : S_PZ;
      end
      S_PSR: begin
        cmd.rd_row = IDX_W'(y_r);
        cmd.rd_col = IDX_W'(x_r);
        state_nxt  = S_PSC;
      end
      S_PSC: begin
        if (stat.better) begin
          cmd.best_upd = 1'b1;
          piv_nxt      = y_r;
        end
        y_nxt     = y_r + 1'b1;
        state_nxt = (y_r + 1'b1 < n_r) ? S_PSR : S_PZ;
      end
      S_PZ: begin
        i_nxt = '0;
        if (stat.best_zero) begin
          state_nxt = S_NEXT;
        end else if (piv_r != x_r) begin
          state_nxt = S_SW1;
        end else begin
          state_nxt = S_PV0;
        end
      end
      S_SW1: begin
        cmd.rd_row = IDX_W'(x_r);
        cmd.rd_col = IDX_W'(i_r);
        state_nxt  = S_SW2;
      end
      S_SW2: begin
        cmd.rd_row    = IDX_W'(piv_r);
        cmd.rd_col    = IDX_W'(i_r);
        cmd.cap_a     = 1'b1;
        cmd.perm_addr = IDX_W'(x_r);
        cmd.perm_cap  = (i_r == '0);
        state_nxt     = S_SW3;
      end
      S_SW3: begin
        cmd.wr_row    = IDX_W'(x_r);
        cmd.wr_col    = IDX_W'(i_r);
        cmd.we_u      = 1'b1;
        cmd.we_l      = i_r < x_r;
        cmd.wsel      = WS_RD;
        cmd.perm_addr = IDX_W'(piv_r);
        cmd.perm_we   = (i_r == '0);
        cmd.perm_wrow = IDX_W'(x_r);
        state_nxt     = S_SW4;
      end
      S_SW4: begin
        cmd.wr_row    = IDX_W'(piv_r);
        cmd.wr_col    = IDX_W'(i_r);
        cmd.we_u      = 1'b1;
        cmd.we_l      = i_r < x_r;
        cmd.wsel      = WS_TMP;
        cmd.perm_we   = (i_r == '0);
        cmd.perm_wtmp = 1'b1;
        cmd.perm_wrow = IDX_W'(piv_r);
        if (i_r == DIM_W'(MAX_DIM - 1)) begin
          cmd.swaps_inc = 1'b1;
          state_nxt     = S_PV0;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SW1;
        end
      end
      S_PV0: begin
        cmd.rd_row = IDX_W'(x_r);
        cmd.rd_col = IDX_W'(x_r);
        state_nxt  = S_PV1;
      end
      S_PV1: begin
        cmd.pv_load = 1'b1;
        y_nxt       = x_r + 1'b1;
        state_nxt   = (x_r + 1'b1 < n_r) ? S_E1 : S_NEXT;
      end
      S_E1: begin
        cmd.rd_row = IDX_W'(y_r);
        cmd.rd_col = IDX_W'(x_r);
        state_nxt  = S_E2;
      end
      S_E2: begin
        if (stat.cur_zero) begin
          state_nxt = S_YNEXT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.f_load = 1'b1;
          state_nxt  = S_EW;
        end
      end
      S_EW: begin
        cmd.wr_row = IDX_W'(y_r);
        cmd.wr_col = IDX_W'(x_r);
        cmd.we_u   = 1'b1;
        cmd.we_l   = 1'b1;
        cmd.wsel   = WS_ELIM;
        i_nxt      = x_r + 1'b1;
        state_nxt  = (x_r + 1'b1 < n_r) ? S_I1 : S_YNEXT;
      end
      S_I1: begin
        cmd.rd_row = IDX_W'(x_r);
        cmd.rd_col = IDX_W'(i_r);
        state_nxt  = S_I2;
      end
      S_I2: begin
        cmd.uxi_load = 1'b1;
        cmd.rd_row   = IDX_W'(y_r);
        cmd.rd_col   = IDX_W'(i_r);
        state_nxt    = S_I3;
      end
      S_I3: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_I4;
      end
      S_I4: begin
        cmd.wr_row = IDX_W'(y_r);
        cmd.wr_col = IDX_W'(i_r);
        cmd.we_u   = 1'b1;
        cmd.wsel   = WS_UPD;
        if (i_r + 1'b1 < n_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_I1;
        end else begin
          state_nxt = S_YNEXT;
        end
      end
      S_YNEXT: begin
        if (y_r + 1'b1 < n_r) begin
          y_nxt     = y_r + 1'b1;
          state_nxt = S_E1;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (x_r + 1'b1 < n_r) begin
          x_nxt     = x_r + 1'b1;
          state_nxt = S_PS0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_load  = 1'b1;
        cmd.out_src   = SRC_DONE;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      i_r         <= '0;
      piv_r       <= '0;
      n_r         <= DIM_W'(MAX_DIM);
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      i_r         <= i_nxt;
      piv_r       <= piv_nxt;
      n_r         <= n_nxt;
      inside_r    <= inside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    sel_r <= sel_nxt;
  end

  `LUP_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE, "input taken outside idle")
  `LUP_ASSERT_IMP(a_slot_free, (state_r == S_RDO) || (state_r == S_DONE), !out_valid_r, "result slot still occupied")
  `LUP_ASSERT_NXT(a_div_runs, (state_r == S_E2) && cmd.div_start, stat.div_busy, "divider did not start")
  `LUP_ASSERT_IMP(a_col_range, state_r != S_IDLE, x_r < n_r, "column counter beyond matrix size")

endmodule

// ===== design/lu_decompose_partial_pivot.sv =====
// ----------------------------------------------------------------------------
// LU decomposition with partial pivoting
// Element load, in-place PA = LU factorisation in signed Q16.16 and read-back
// of P, L and U.
// ----------------------------------------------------------------------------
// A write command passes through a write state; a read command passes through a
// read state and an output state, and its result is registered. A decompose
// command of size N runs on an L and U RAM pair, each with one write and one
// read port, and a bit-serial 48-step divider: per column a pivot search, a row
// exchange over all MAX_DIM columns when the pivot moves, and per eliminated row
// a division and a read, multiply and write of each updated element. No new
// command is taken while a decomposition runs.
// ----------------------------------------------------------------------------
module lu_decompose_partial_pivot
  import lup_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [IN_IDX_W-1:0] in_row_index,
  input  logic [IN_IDX_W-1:0] in_col_index,
  input  logic [DATA_W-1:0]   in_element_value,
  input  logic [SEL_W-1:0]    in_matrix_select,
  input  logic [DIMF_W-1:0]   in_dimension,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [DATA_W-1:0]   out_read_value,
  output logic [SWAP_W-1:0]   out_swap_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_W-1:0]    cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lup_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_matrix_select (in_matrix_select),
    .in_dimension     (in_dimension),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .stat             (stat)
  );

  lup_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_element_value (in_element_value),
    .cfg_we           (cfg_valid),
    .cfg_data         (cfg_data),
    .out_result_kind  (out_result_kind),
    .out_read_value   (out_read_value),
    .out_swap_count   (out_swap_count)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// LU decomposition with partial pivoting testbench
// Loads matrices, factors them and reads back P, L and U. An in-bench
// scoreboard computes every result and compares each output transfer
// against it, under several zero tolerances and idling patterns.
// ----------------------------------------------------------------------------
module tb;
  import lup_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
  localparam logic [SEL_W-1:0] MSEL_UNUSED = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] value;
    logic [SWAP_W-1:0] swaps;
  } lu_result_t;

  class lu_scoreboard;
    int                unsigned errors;
    logic [DATA_W-1:0] upper [DEPTH];
    logic [DATA_W-1:0] lower [DEPTH];
    logic [IDX_W-1:0]  perm [MAX_DIM];
    logic [SWAP_W-1:0] swaps;
    int                size;
    logic [TOL_W-1:0]  tol;
    lu_result_t        pending [$];

    function new();
      errors = 0;
      foreach (upper[i]) upper[i] = '0;
      set_identity();
      swaps = '0;
      size  = MAX_DIM;
      tol   = 1;
    endfunction

    function void set_identity();
      for (int r = 0; r < MAX_DIM; r++) begin
        perm[r] = r;
        for (int c = 0; c < MAX_DIM; c++)
          lower[r*MAX_DIM+c] = (r == c) ? ONE_Q : '0;
      end
    endfunction

    function logic [DATA_W-1:0] magn(logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function bit near_zero(logic [DATA_W-1:0] v);
      return magn(v) <= {1'b0, tol};
    endfunction

    function logic [DATA_W-1:0] sat(longint v);
      if (v > longint'(32'sh7fffffff)) return DMAX_Q;
      if (v < -longint'(64'h80000000)) return DMIN_Q;
      return v[DATA_W-1:0];
    endfunction

    function void factorise();
      int piv;
      logic [DATA_W-1:0] pv, cur, f, t;
      logic [IDX_W-1:0] tp;
      longint q;
      set_identity();
      swaps = '0;
      for (int x = 0; x < size; x++) begin
        piv = x;
        for (int y = x + 1; y < size; y++)
          if (magn(upper[y*MAX_DIM+x]) > magn(upper[piv*MAX_DIM+x])) piv = y;
        if (near_zero(upper[piv*MAX_DIM+x])) continue;
        if (piv != x) begin
          for (int i = 0; i < MAX_DIM; i++) begin
            t = upper[x*MAX_DIM+i];
            upper[x*MAX_DIM+i] = upper[piv*MAX_DIM+i];
            upper[piv*MAX_DIM+i] = t;
          end
          tp = perm[x]; perm[x] = perm[piv]; perm[piv] = tp;
          for (int i = 0; i < x; i++) begin
            t = lower[x*MAX_DIM+i];
            lower[x*MAX_DIM+i] = lower[piv*MAX_DIM+i];
            lower[piv*MAX_DIM+i] = t;
          end
          swaps = swaps + 1'b1;
        end
        pv = upper[x*MAX_DIM+x];
        for (int y = x + 1; y < size; y++) begin
          cur = upper[y*MAX_DIM+x];
          if (near_zero(cur)) continue;
          f = sat((longint'(signed'(cur)) * (longint'(1) << FRAC_BITS))
                  / longint'(signed'(pv)));
          upper[y*MAX_DIM+x] = '0;
          for (int i = x + 1; i < size; i++) begin
            q = (longint'(signed'(f)) * longint'(signed'(upper[x*MAX_DIM+i])))
                / (longint'(1) << FRAC_BITS);
            t = sat(longint'(signed'(upper[y*MAX_DIM+i])) - q);
            upper[y*MAX_DIM+i] = near_zero(t) ? '0 : t;
          end
          lower[y*MAX_DIM+x] = f;
        end
      end
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [2:0] r, logic [2:0] c,
                             logic [DATA_W-1:0] val, logic [SEL_W-1:0] sel,
                             logic [DIMF_W-1:0] dim);
      lu_result_t res;
      res.kind  = KIND_READ;
      res.value = '0;
      case (op)
        OP_WRITE: upper[r*MAX_DIM+c] = val;
        OP_DECOMP: begin
          size = (dim < 1) ? 1 : (dim > MAX_DIM) ? MAX_DIM : dim;
          factorise();
          res.kind  = KIND_DONE;
          res.swaps = swaps;
          pending.push_back(res);
        end
        OP_READ: begin
          case (sel)
            MSEL_P:  res.value = (perm[r] == c) ? ONE_Q : '0;
            MSEL_L:  res.value = lower[r*MAX_DIM+c];
            MSEL_U:  res.value = upper[r*MAX_DIM+c];
            default: res.value = '0;
          endcase
          res.swaps = swaps;
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(lu_result_t got);
      lu_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d value=%h", got.kind, got.value);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("result_kind expected %0d actual %0d", exp_r.kind, got.kind);
        errors++;
      end
      if (got.value !== exp_r.value) begin
        $error("read_value expected %h actual %h", exp_r.value, got.value);
        errors++;
      end
      if (got.swaps !== exp_r.swaps) begin
        $error("swap_count expected %0d actual %0d", exp_r.swaps, got.swaps);
        errors++;
      end
    endfunction
  endclass

  logic                clk, rst_n;
  logic                in_valid, in_ready;
  logic [OP_W-1:0]     in_opcode;
  logic [IN_IDX_W-1:0] in_row_index, in_col_index;
  logic [DATA_W-1:0]   in_element_value;
  logic [SEL_W-1:0]    in_matrix_select;
  logic [DIMF_W-1:0]   in_dimension;
  logic                out_valid, out_ready, out_result_kind;
  logic [DATA_W-1:0]   out_read_value;
  logic [SWAP_W-1:0]   out_swap_count;
  logic                cfg_valid, cfg_ready;
  logic [TOL_W-1:0]    cfg_data;

  lu_scoreboard sb = new();
  int unsigned  send_idle, recv_stall, sent;

  lu_decompose_partial_pivot dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("lu_decompose_partial_pivot: mismatch");
    $finish;
  end

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_result_kind, out_read_value, out_swap_count});

  task automatic send(logic [OP_W-1:0] op, logic [2:0] r, logic [2:0] c,
                      logic [DATA_W-1:0] val, logic [SEL_W-1:0] sel,
                      logic [DIMF_W-1:0] dim);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_opcode = op; in_row_index = r; in_col_index = c;
    in_element_value = val; in_matrix_select = sel; in_dimension = dim;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, r, c, val, sel, dim);
    sent++;
    @(negedge clk);
  endtask

  task automatic put(int r, int c, logic [DATA_W-1:0] v);
    send(OP_WRITE, r, c, v, $urandom, $urandom);
  endtask

  task automatic peek(logic [SEL_W-1:0] sel, int r, int c);
    send(OP_READ, r, c, $urandom, sel, $urandom);
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] t);
    drain();
    cfg_data  = t;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.tol = t;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(1) ? DMAX_Q : DMIN_Q;
      3: return $urandom_range(6) - 3;
      default: return $urandom_range(1 << 20) - (1 << 19);
    endcase
  endfunction

  task automatic directed();
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < MAX_DIM; c++)
        put(r, c, rand_elem());
    put(0, 0, DMIN_Q); put(1, 0, DMAX_Q); put(7, 7, '1);
    peek(MSEL_P, 0, 0); peek(MSEL_L, 7, 7); peek(MSEL_U, 0, 0);
    peek(MSEL_UNUSED, 3, 5);
    send(OP_UNUSED, 7, 7, '1, MSEL_UNUSED, '1);
    send(OP_DECOMP, 0, 0, '0, MSEL_P, 4'd0);
    peek(MSEL_U, 0, 0);
    put(0, 0, ONE_Q); put(0, 1, 32'h0002_0000);
    put(1, 0, 32'd1); put(1, 1, ONE_Q);
    send(OP_DECOMP, 0, 0, '0, MSEL_P, 4'd2);
    peek(MSEL_L, 1, 0); peek(MSEL_U, 1, 0);
    put(0, 0, 32'd3); put(1, 0, DMAX_Q); put(1, 1, DMIN_Q);
    send(OP_DECOMP, 7, 7, '1, MSEL_U, 4'd2);
    send(OP_DECOMP, 7, 7, '1, MSEL_U, 4'd2);
    peek(MSEL_P, 0, 1); peek(MSEL_L, 1, 0); peek(MSEL_U, 1, 1);
    send(OP_DECOMP, 0, 0, '0, MSEL_P, 4'd15);
    peek(MSEL_P, 7, 7);
  endtask

  task automatic random_part(int quota);
    int target, d;
    target = sent + quota;
    while (sent < target) begin
      case ($urandom_range(19))
        0:       d = 8 + $urandom_range(7);
        1:       d = 0;
        default: d = 1 + $urandom_range(3);
      endcase
      for (int r = 0; r < ((d < 1) ? 1 : (d > 8 ? 8 : d)); r++)
        for (int c = 0; c < ((d < 1) ? 1 : (d > 8 ? 8 : d)); c++)
          if ($urandom_range(9) != 0) put(r, c, rand_elem());
      if ($urandom_range(9) == 0) send(OP_UNUSED, $urandom, $urandom, $urandom,
                                       $urandom, $urandom);
      send(OP_DECOMP, $urandom, $urandom, $urandom, $urandom, d);
      repeat (2 + $urandom_range(6)) peek($urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_data = '0;
    in_opcode = '0; in_row_index = '0; in_col_index = '0;
    in_element_value = '0; in_matrix_select = '0; in_dimension = '0;
    send_idle = 0; recv_stall = 0; sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    set_tolerance(1);
    directed();
    for (int p = 0; p < 5; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 49; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 49; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      case (p)
        0: set_tolerance(0);
        1: set_tolerance(31'h7fff_ffff);
        2: set_tolerance($urandom_range(4096));
        3: set_tolerance($urandom);
        default: set_tolerance(1);
      endcase
      random_part(70);
      if (p == 2) drain();
    end
    in_valid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("lu_decompose_partial_pivot: match");
    else
      $display("lu_decompose_partial_pivot: mismatch");
    $finish;
  end
endmodule
